// ===== rtl/u8n1_pkg.sv =====
// Shared constants for the 8N1 UART transceiver: reset values, default
// parameters and the bit layout of the stream payloads. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u8n1_pkg;

    localparam int BYTE_W          = 8;
    localparam int BIT_SEL_W       = $clog2(BYTE_W);
    localparam int IDX_W           = 4;
    localparam int PERIOD_W        = 16;

    localparam int DATA_BITS_DEF   = 8;
    localparam int TIMER_WIDTH_DEF = 16;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd2604;

    // input tdata layout, lowest bit first
    localparam int IN_W        = 16;
    localparam int I_RX_LINE   = 0;
    localparam int I_TX_START  = 1;
    localparam int I_TX_BYTE   = 2;

    // output tdata layout, lowest bit first
    localparam int OUT_W       = 16;
    localparam int O_TX_LINE   = 0;
    localparam int O_TX_BUSY   = 1;
    localparam int O_RX_VALID  = 2;
    localparam int O_RX_BYTE   = 3;
    localparam int O_RX_BUSY   = 11;
    localparam int OUT_USED    = 12;

endpackage

`default_nettype wire

// ===== rtl/uart_8n1_transceiver.sv =====
// 8N1 UART transceiver: each stream transfer is one timer tick, registered result
// with a skid stage. Depends on u8n1_pkg.
//
// Usage: each transfer on the slave stream is one tick of the bit timers and
// carries the sampled receive line, a transmit-start flag and a byte. Each
// accepted transfer yields exactly one result transfer on the master stream
// with the transmit line level, transmit busy, a receive-valid pulse, the
// received byte (zero when not valid) and receive busy.
// The result is registered in the output register, or in the skid stage on a stall.
// Throughput: one transfer per cycle while o_s_axis_tready is high; the tick
// update is one pass of short logic (one timer increment and compare per
// direction) between the state registers and the output register.
// Stall: when the master side stalls, one more transfer is taken into the
// skid stage; o_s_axis_tready then drops until the output register drains.
// Reset: synchronous, active low; clears both directions to idle, the line
// history to high and the bit period to 2604 ticks. i_cfg_we writes the bit
// period at once and is meant for use while the streams are idle.
`timescale 1ns / 1ps
`default_nettype none

module uart_8n1_transceiver
    import u8n1_pkg::*;
#(
    parameter int DATA_BITS   = DATA_BITS_DEF,
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [PERIOD_W-1:0] i_cfg_wdata,
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    // [0] rx_line, [1] tx_start, [9:2] tx_byte, [15:10] zero
    input  wire logic [IN_W-1:0]     i_s_axis_tdata,
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte, [11] rx_busy,
    // [15:12] zero
    output logic [OUT_W-1:0]         o_m_axis_tdata
);

    localparam int CMP_W = (TIMER_WIDTH > PERIOD_W) ? TIMER_WIDTH : PERIOD_W;
    localparam logic [CMP_W-1:0] TMAX = CMP_W'({TIMER_WIDTH{1'b1}});

    function automatic logic timer_fire(input logic [TIMER_WIDTH-1:0] cnt,
                                        input logic [PERIOD_W-1:0]    tgt);
        logic [CMP_W-1:0] c;
        logic [CMP_W-1:0] t;
        c = CMP_W'(cnt);
        t = CMP_W'(tgt);
        if (t > TMAX) begin
            t = TMAX;
        end
        return c >= t;
    endfunction

    logic [PERIOD_W-1:0]    r_bit_period;

    logic                   r_rx_prev,   n_rx_prev;
    logic                   r_rx_half,   n_rx_half;
    logic                   r_rx_active, n_rx_active;
    logic [TIMER_WIDTH-1:0] r_rx_timer,  n_rx_timer;
    logic [IDX_W-1:0]       r_rx_idx,    n_rx_idx;
    logic [BYTE_W-1:0]      r_rx_shift,  n_rx_shift;
    logic                   r_tx_active, n_tx_active;
    logic [TIMER_WIDTH-1:0] r_tx_timer,  n_tx_timer;
    logic [IDX_W-1:0]       r_tx_idx,    n_tx_idx;
    logic [BYTE_W-1:0]      r_tx_shift,  n_tx_shift;
    logic                   r_tx_level,  n_tx_level;

    logic                   r_m_valid;
    logic [OUT_W-1:0]       r_m_data;
    logic                   r_sk_valid;
    logic [OUT_W-1:0]       r_sk_data;

    logic                   in_fire;
    logic                   in_line;
    logic                   in_start;
    logic [BYTE_W-1:0]      in_byte;
    logic [TIMER_WIDTH-1:0] rx_inc;
    logic [TIMER_WIDTH-1:0] tx_inc;
    logic [PERIOD_W-1:0]    rx_target;
    logic                   rx_fire;
    logic                   tx_fire;
    logic                   n_valid;
    logic [BYTE_W-1:0]      n_got;
    logic [OUT_W-1:0]       n_res;

    assign in_line   = i_s_axis_tdata[I_RX_LINE];
    assign in_start  = i_s_axis_tdata[I_TX_START];
    assign in_byte   = i_s_axis_tdata[I_TX_BYTE +: BYTE_W];

    assign o_s_axis_tready = !r_sk_valid;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    assign rx_inc    = r_rx_timer + 1'b1;
    assign tx_inc    = r_tx_timer + 1'b1;
    assign rx_target = r_rx_active ? r_bit_period : (r_bit_period >> 1);
    assign rx_fire   = timer_fire(rx_inc, rx_target);
    assign tx_fire   = timer_fire(tx_inc, r_bit_period);

    // receiver
    always_comb begin
        n_rx_prev   = in_line;
        n_rx_half   = r_rx_half;
        n_rx_active = r_rx_active;
        n_rx_timer  = r_rx_timer;
        n_rx_idx    = r_rx_idx;
        n_rx_shift  = r_rx_shift;
        n_valid     = 1'b0;
        n_got       = '0;
        if (!r_rx_active) begin
            if (r_rx_prev && !in_line) begin
                n_rx_half  = 1'b1;
                n_rx_timer = '0;
            end else if (r_rx_half) begin
                n_rx_timer = rx_inc;
                if (rx_fire) begin
                    n_rx_timer  = '0;
                    n_rx_half   = 1'b0;
                    n_rx_active = 1'b1;
                    n_rx_idx    = '0;
                    n_rx_shift  = '0;
                end
            end
        end else begin
            n_rx_timer = rx_inc;
            if (rx_fire) begin
                n_rx_timer = '0;
                if (r_rx_idx >= IDX_W'(DATA_BITS)) begin
                    n_rx_active = 1'b0;
                    n_rx_idx    = '0;
                    if (in_line) begin
                        n_valid = 1'b1;
                        n_got   = r_rx_shift;
                    end
                end else begin
                    n_rx_shift = r_rx_shift
                               | (BYTE_W'(in_line) << r_rx_idx[BIT_SEL_W-1:0]);
                    n_rx_idx   = r_rx_idx + 1'b1;
                end
            end
        end
    end

    // transmitter
    always_comb begin
        n_tx_active = r_tx_active;
        n_tx_timer  = r_tx_timer;
        n_tx_idx    = r_tx_idx;
        n_tx_shift  = r_tx_shift;
        n_tx_level  = r_tx_level;
        if (!r_tx_active) begin
            if (in_start) begin
                n_tx_active = 1'b1;
                n_tx_idx    = '0;
                n_tx_shift  = in_byte;
                n_tx_level  = 1'b0;
                n_tx_timer  = '0;
            end
        end else begin
            n_tx_timer = tx_inc;
            if (tx_fire) begin
                n_tx_timer = '0;
                priority if (r_tx_idx < IDX_W'(DATA_BITS)) begin
                    n_tx_level = r_tx_shift[r_tx_idx[BIT_SEL_W-1:0]];
                    n_tx_idx   = r_tx_idx + 1'b1;
                end else if (r_tx_idx == IDX_W'(DATA_BITS)) begin
                    n_tx_level = 1'b1;
                    n_tx_idx   = r_tx_idx + 1'b1;
                end else begin
                    n_tx_active = 1'b0;
                    n_tx_level  = 1'b1;
                    n_tx_idx    = '0;
                end
            end
        end
    end

    assign n_res = {(OUT_W-OUT_USED)'(0), (n_rx_half | n_rx_active), n_got, n_valid,
                    n_tx_active, n_tx_level};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= BIT_PERIOD_RST;
        end else if (i_cfg_we) begin
            r_bit_period <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_prev   <= 1'b1;
            r_rx_half   <= 1'b0;
            r_rx_active <= 1'b0;
            r_rx_timer  <= '0;
            r_rx_idx    <= '0;
            r_rx_shift  <= '0;
            r_tx_active <= 1'b0;
            r_tx_timer  <= '0;
            r_tx_idx    <= '0;
            r_tx_shift  <= '0;
            r_tx_level  <= 1'b1;
        end else if (in_fire) begin
            r_rx_prev   <= n_rx_prev;
            r_rx_half   <= n_rx_half;
            r_rx_active <= n_rx_active;
            r_rx_timer  <= n_rx_timer;
            r_rx_idx    <= n_rx_idx;
            r_rx_shift  <= n_rx_shift;
            r_tx_active <= n_tx_active;
            r_tx_timer  <= n_tx_timer;
            r_tx_idx    <= n_tx_idx;
            r_tx_shift  <= n_tx_shift;
            r_tx_level  <= n_tx_level;
        end
    end

    // output register and skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid  <= 1'b0;
            r_sk_valid <= 1'b0;
        end else if (!r_m_valid || i_m_axis_tready) begin
            if (r_sk_valid) begin
                r_m_valid  <= 1'b1;
                r_sk_valid <= 1'b0;
            end else begin
                r_m_valid  <= in_fire;
            end
        end else if (in_fire) begin
            r_sk_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_m_valid || i_m_axis_tready) begin
            r_m_data <= r_sk_valid ? r_sk_data : n_res;
        end else if (in_fire) begin
            r_sk_data <= n_res;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

// ===== rtl/u8n1_checker.sv =====
// Port-level assertions for the 8N1 UART transceiver and the bind that
// attaches them to the top level. Depends on u8n1_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u8n1_checker
    import u8n1_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                o_s_axis_tready,
    input wire logic                o_m_axis_tvalid,
    input wire logic                i_m_axis_tready,
    input wire logic [OUT_W-1:0]    o_m_axis_tdata
);

    // a completed byte ends the frame
    a_valid_ends_rx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[O_RX_VALID] |-> !o_m_axis_tdata[O_RX_BUSY])
        else $error("rx_valid with rx_busy set");

    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[O_RX_VALID]
            |-> o_m_axis_tdata[O_RX_BYTE +: BYTE_W] == '0)
        else $error("rx_byte nonzero without rx_valid");

    a_tx_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[O_TX_BUSY] |-> o_m_axis_tdata[O_TX_LINE])
        else $error("tx_line low while transmitter idle");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready
            |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output transfer changed");

    // an empty output register never blocks the input
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready)
        else $error("input blocked with empty output");

endmodule

bind uart_8n1_transceiver u8n1_checker u_chk (.*);

`default_nettype wire

// ===== tb/sv/uart_8n1_transceiver_tb.sv =====
// Self-checking testbench for uart_8n1_transceiver: drives one tick per stream
// transfer and checks every result transfer against an in-bench UART predictor or typed rows.
// Depends on u8n1_pkg and the transceiver RTL.
`timescale 1ns / 1ps

module uart_8n1_transceiver_tb;
    import u8n1_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int N_DIR        = 22;
    localparam int N_PHASES     = 6;

    typedef enum logic {ROW_TICK, ROW_PERIOD} row_kind_e;

    typedef struct packed {
        logic              tx_line;
        logic              tx_busy;
        logic              rx_valid;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_busy;
    } status_t;

    typedef struct packed {
        row_kind_e           kind;
        logic [PERIOD_W-1:0] period;
        logic                rx_line;
        logic                tx_start;
        logic [BYTE_W-1:0]   tx_b;
        logic                typed;
        status_t             want;
    } row_t;

    typedef struct packed {
        logic                line_prev;
        logic                half_wait;
        logic                rx_on;
        logic [PERIOD_W-1:0] rx_tmr;
        logic [IDX_W-1:0]    rx_idx;
        logic [BYTE_W-1:0]   rx_sr;
        logic                tx_on;
        logic [PERIOD_W-1:0] tx_tmr;
        logic [IDX_W-1:0]    tx_idx;
        logic [BYTE_W-1:0]   tx_sr;
        logic                tx_lvl;
    } uart_state_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [PERIOD_W-1:0] i_cfg_wdata;
    logic                i_s_axis_tvalid;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready;
    logic [OUT_W-1:0]    o_m_axis_tdata;

    uart_state_t         uart;
    logic [PERIOD_W-1:0] bit_period;
    status_t             status_q [$];
    int                  bad_results;
    int                  ticks_sent;
    int                  cycle_count;
    int                  src_idle_pct;
    int                  sink_idle_pct;
    row_t                dir_rows [0:N_DIR-1];

    logic                out_fire;
    logic [OUT_W-1:0]    out_word;
    status_t             seen;
    status_t             owed;

    uart_8n1_transceiver dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic timer_done(inout logic [PERIOD_W-1:0] tmr,
                                        input logic [PERIOD_W-1:0] target);
        tmr = tmr + 1'b1;
        if (tmr >= target) begin
            tmr = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void uart_reset();
        uart.line_prev = 1'b1;
        uart.half_wait = 1'b0;
        uart.rx_on     = 1'b0;
        uart.rx_tmr    = '0;
        uart.rx_idx    = '0;
        uart.rx_sr     = '0;
        uart.tx_on     = 1'b0;
        uart.tx_tmr    = '0;
        uart.tx_idx    = '0;
        uart.tx_sr     = '0;
        uart.tx_lvl    = 1'b1;
        bit_period     = BIT_PERIOD_RST;
    endfunction

    function automatic status_t uart_tick(input logic line, input logic start,
                                          input logic [BYTE_W-1:0] tx_b);
        status_t r;
        r = '0;
        if (!uart.rx_on) begin
            if (uart.line_prev && !line) begin
                uart.half_wait = 1'b1;
                uart.rx_tmr    = '0;
            end else if (uart.half_wait) begin
                if (timer_done(uart.rx_tmr, bit_period >> 1)) begin
                    uart.half_wait = 1'b0;
                    uart.rx_on     = 1'b1;
                    uart.rx_idx    = '0;
                    uart.rx_sr     = '0;
                end
            end
        end else if (timer_done(uart.rx_tmr, bit_period)) begin
            if (uart.rx_idx >= DATA_BITS_DEF) begin
                uart.rx_on  = 1'b0;
                uart.rx_idx = '0;
                if (line) begin
                    r.rx_valid = 1'b1;
                    r.rx_byte  = uart.rx_sr;
                end
            end else begin
                uart.rx_sr[uart.rx_idx[BIT_SEL_W-1:0]] =
                    uart.rx_sr[uart.rx_idx[BIT_SEL_W-1:0]] | line;
                uart.rx_idx = uart.rx_idx + 1'b1;
            end
        end
        uart.line_prev = line;

        if (!uart.tx_on) begin
            if (start) begin
                uart.tx_on  = 1'b1;
                uart.tx_idx = '0;
                uart.tx_sr  = tx_b;
                uart.tx_lvl = 1'b0;
                uart.tx_tmr = '0;
            end
        end else if (timer_done(uart.tx_tmr, bit_period)) begin
            if (uart.tx_idx < DATA_BITS_DEF) begin
                uart.tx_lvl = uart.tx_sr[uart.tx_idx[BIT_SEL_W-1:0]];
                uart.tx_idx = uart.tx_idx + 1'b1;
            end else if (uart.tx_idx == DATA_BITS_DEF) begin
                uart.tx_lvl = 1'b1;
                uart.tx_idx = uart.tx_idx + 1'b1;
            end else begin
                uart.tx_on  = 1'b0;
                uart.tx_lvl = 1'b1;
                uart.tx_idx = '0;
            end
        end

        r.tx_line = uart.tx_lvl;
        r.tx_busy = uart.tx_on;
        r.rx_busy = uart.half_wait | uart.rx_on;
        return r;
    endfunction

    task automatic drive_tick(input logic line, input logic start,
                              input logic [BYTE_W-1:0] tx_b,
                              input logic typed, input status_t want);
        logic [IN_W-1:0] word;
        logic            acc;
        status_t         got;
        word = '0;
        word[I_RX_LINE]            = line;
        word[I_TX_START]           = start;
        word[I_TX_BYTE +: BYTE_W]  = tx_b;
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do begin
            @(negedge i_clk);
            acc = o_s_axis_tready;
            @(posedge i_clk);
        end while (!acc);
        got = uart_tick(line, start, tx_b);
        status_q.push_back(typed ? want : got);
        ticks_sent++;
    endtask

    task automatic drive_line(input logic line);
        drive_tick(line, $urandom_range(7) == 0, BYTE_W'($urandom), 1'b0, '0);
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (status_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        bit_period = value;
    endtask

    task automatic run_phase(input logic [PERIOD_W-1:0] per, input int len);
        int               stop_at;
        int               hold;
        int               pick;
        int               nbits;
        logic [9:0]       frame_bits;
        settle();
        write_period(per);
        stop_at = ticks_sent + len;
        while (ticks_sent < stop_at) begin
            hold = (per > 64) ? $urandom_range(4, 1) : per;
            pick = $urandom_range(99);
            if (pick < 75) begin
                frame_bits = {$urandom_range(9) != 0, BYTE_W'($urandom), 1'b0};
                nbits = (pick < 62) ? 10 : $urandom_range(9, 1);
                repeat ($urandom_range(hold, 1)) drive_line(1'b1);
                for (int i = 0; i < nbits; i++) begin
                    repeat (hold) drive_line(frame_bits[i]);
                end
            end else begin
                repeat ($urandom_range(2 * hold, 1)) drive_line($urandom_range(1));
            end
        end
    endtask

    always begin
        @(negedge i_clk);
        out_fire = o_m_axis_tvalid && i_m_axis_tready;
        out_word = o_m_axis_tdata;
        @(posedge i_clk);
        if (out_fire) begin
            seen.tx_line  = out_word[O_TX_LINE];
            seen.tx_busy  = out_word[O_TX_BUSY];
            seen.rx_valid = out_word[O_RX_VALID];
            seen.rx_byte  = out_word[O_RX_BYTE +: BYTE_W];
            seen.rx_busy  = out_word[O_RX_BUSY];
            if (status_q.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected transfer: actual %h", seen);
            end else begin
                owed = status_q.pop_front();
                if (seen.tx_line !== owed.tx_line || seen.tx_busy !== owed.tx_busy ||
                    seen.rx_valid !== owed.rx_valid || seen.rx_byte !== owed.rx_byte ||
                    seen.rx_busy !== owed.rx_busy) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: expected %h actual %h", owed, seen);
                end
            end
        end
        i_m_axis_tready <= (sink_idle_pct == 0) || ($urandom_range(99) >= sink_idle_pct);
    end

    initial begin
        int phase_period [N_PHASES];
        int phase_len    [N_PHASES];

        phase_period = '{4, 65535, 5, 7, 0, 6};
        phase_len    = '{160, 30, 180, 170, 180, 180};
        dir_rows = '{
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h00, 1'b1, '{1'b1, 1'b0, 1'b0, 8'h00, 1'b1}},
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'hFF, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b1, 8'hFF, 1'b1, '{1'b0, 1'b1, 1'b0, 8'h00, 1'b1}},
            '{ROW_TICK,   16'd0,     1'b1, 1'b1, 8'h00, 1'b0, '0},
            '{ROW_PERIOD, 16'd4,     1'b1, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b1, 8'hAA, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h55, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h01, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'h80, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'hFE, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b0, 8'h7F, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b1, 8'hFF, 1'b0, '0},
            '{ROW_PERIOD, 16'hFFFF,  1'b1, 1'b0, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b1, 8'h00, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b0, 1'b1, 8'hFF, 1'b0, '0},
            '{ROW_TICK,   16'd0,     1'b1, 1'b0, 8'h00, 1'b0, '0}
        };

        bad_results   = 0;
        ticks_sent    = 0;
        cycle_count   = 0;
        src_idle_pct  = 16;
        sink_idle_pct = 75;
        uart_reset();

        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_wdata     <= BIT_PERIOD_RST;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].kind == ROW_PERIOD) begin
                settle();
                write_period(dir_rows[r].period);
            end else begin
                drive_tick(dir_rows[r].rx_line, dir_rows[r].tx_start, dir_rows[r].tx_b,
                           dir_rows[r].typed, dir_rows[r].want);
            end
        end

        for (int p = 0; p < N_PHASES; p++) begin
            src_idle_pct  = (p < 2) ? 16 : (p < 4) ? 75 : 0;
            sink_idle_pct = (p < 2) ? 75 : (p < 4) ? 16 : 0;
            run_phase((phase_period[p] == 0) ? PERIOD_W'($urandom_range(12, 4))
                                             : PERIOD_W'(phase_period[p]),
                      phase_len[p]);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (bad_results == 0 && status_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
